// ----- design/optimal_bst_builder_assert.svh -----
// ----------------------------------------------------------------------------
// optimal_bst_builder_assert
// Assertion macros for the optimal BST builder.
// ----------------------------------------------------------------------------
`ifndef OPTIMAL_BST_BUILDER_ASSERT_SVH
`define OPTIMAL_BST_BUILDER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define OBST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define OBST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- design/obst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obst_pkg
// Shared widths and types for the optimal BST builder.
// ----------------------------------------------------------------------------
package obst_pkg;
   localparam int KEY_W    = 6;
   localparam int WGT_IN_W = 16;
   localparam int WGT_W    = 23;
   localparam int COST_W   = 28;
   localparam logic [WGT_W-1:0]  WEIGHT_MAX = {WGT_W{1'b1}};
   localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};

   // one pending subtree span for the preorder walk
   typedef struct packed {
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
      logic [KEY_W-1:0] parent;
      logic             left;
   } span_type;
endpackage
`default_nettype wire

// ----- design/optimal_bst_builder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// optimal_bst_builder: optimal BST by dynamic programming, nodes out in preorder.
// Load while req_ready is high; the fill steps ST_WRD and ST_CELL per cell, then
// ST_KRD0, ST_KRD1, ST_KACC per k and ST_WRITE; nodes are sent from ST_ROOT.
// Sequential: no item is taken until the last node transfer. Synchronous reset
// clears controller, stack pointer and rsp_valid; memories are not cleared.
// ----------------------------------------------------------------------------
module optimal_bst_builder #(
   parameter int MAX_KEYS = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [obst_pkg::KEY_W-1:0]    req_key_index,
   input  wire  [obst_pkg::WGT_IN_W-1:0] req_hit_weight,
   input  wire  [obst_pkg::WGT_IN_W-1:0] req_miss_weight,
   input  wire                           req_last_item,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic [obst_pkg::KEY_W-1:0]    rsp_node_key,
   output logic [obst_pkg::KEY_W-1:0]    rsp_parent_key,
   output logic                          rsp_is_left_child,
   output logic [obst_pkg::COST_W-1:0]   rsp_tree_cost,
   output logic                          rsp_last_result
);
   import obst_pkg::*;

   localparam int SIDE   = MAX_KEYS + 1;
   localparam int CELLS  = SIDE * SIDE;
   localparam int CA_W   = $clog2(CELLS);
   localparam int SA_W   = $clog2(SIDE);
   localparam int SP_W   = $clog2(SIDE + 2);

   localparam logic [3:0] ST_LOAD  = 4'd0;
   localparam logic [3:0] ST_CELL  = 4'd1;
   localparam logic [3:0] ST_WRD   = 4'd2;
   localparam logic [3:0] ST_KRD0  = 4'd3;
   localparam logic [3:0] ST_KRD1  = 4'd4;
   localparam logic [3:0] ST_KACC  = 4'd5;
   localparam logic [3:0] ST_WRITE = 4'd6;
   localparam logic [3:0] ST_TOTAL = 4'd7;
   localparam logic [3:0] ST_POP   = 4'd8;
   localparam logic [3:0] ST_ROOT  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;
   localparam logic [3:0] ST_PUSH  = 4'd11;

   // memories
   logic [WGT_IN_W-1:0] hit_mem  [SIDE];
   logic [WGT_IN_W-1:0] miss_mem [SIDE];
   logic [WGT_W-1:0]    wgt_mem  [CELLS];
   logic [COST_W-1:0]   cost_mem [CELLS];
   logic [KEY_W-1:0]    root_mem [CELLS];
   span_type            stk_mem  [SIDE + 2];

   logic [3:0]         state_ff;
   logic [KEY_W-1:0]   n_ff, len_ff, i_ff, k_ff, best_k_ff;
   logic [COST_W:0]    best_ff;
   logic [COST_W-1:0]  c0_ff;
   logic [WGT_W-1:0]   w_ff;
   logic [COST_W-1:0]  total_ff;
   logic [SP_W-1:0]    sp_ff;
   span_type           span_ff;
   logic [KEY_W-1:0]   r_ff;
   logic [1:0]         push_ff;

   logic [WGT_IN_W-1:0] hit_rd, miss_rd;
   logic [WGT_W-1:0]    wgt_rd;
   logic [COST_W-1:0]   cost_rd;
   logic [KEY_W-1:0]    root_rd;
   span_type            stk_rd;

   logic [KEY_W-1:0] j_w;
   assign j_w = i_ff + len_ff;

   function automatic logic [CA_W-1:0] cidx(input logic [KEY_W-1:0] a,
                                            input logic [KEY_W-1:0] b);
      logic [CA_W+KEY_W-1:0] p;
      p = (CA_W+KEY_W)'(a) * (CA_W+KEY_W)'(SIDE) + (CA_W+KEY_W)'(b);
      return p[CA_W-1:0];
   endfunction

   logic req_fire, rsp_fire;
   assign req_ready = (state_ff == ST_LOAD) && !rsp_valid;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // node launch and whether it closes the tree
   logic emit_go, emit_last;
   assign emit_go   = (state_ff == ST_ROOT) && (push_ff != 2'd2) && (!rsp_valid || rsp_fire);
   assign emit_last = (sp_ff == '0) && (root_rd == span_ff.hi) &&
                      (span_ff.lo == root_rd - KEY_W'(1));

   // weight memories: written on load, read at the current j
   always_ff @(posedge clock) begin
      if (req_fire && (req_key_index <= KEY_W'(MAX_KEYS))) begin
         hit_mem[req_key_index[SA_W-1:0]]  <= req_hit_weight;
         miss_mem[req_key_index[SA_W-1:0]] <= req_miss_weight;
      end
      hit_rd  <= hit_mem[j_w[SA_W-1:0]];
      miss_rd <= miss_mem[j_w[SA_W-1:0]];
   end

   // table read addresses by state
   logic [CA_W-1:0] wgt_ra, cost_ra, root_ra;
   always_comb begin
      wgt_ra  = cidx(i_ff, j_w - KEY_W'(1));
      cost_ra = cidx(i_ff, k_ff - KEY_W'(1));
      if (state_ff == ST_KRD0) cost_ra = cidx(k_ff, j_w);
      if (state_ff == ST_TOTAL) cost_ra = cidx(KEY_W'(0), n_ff);
      root_ra = cidx(span_ff.lo, span_ff.hi);
   end

   // full weight and sum for the write
   logic [WGT_W+1:0]  wsum;
   logic [WGT_W-1:0]  wsat;
   logic [COST_W:0]   csum;
   logic [COST_W+1:0] tot;
   logic [COST_W-1:0] csat;
   always_comb begin
      wsum = (WGT_W+2)'(wgt_rd) + (WGT_W+2)'(hit_rd) + (WGT_W+2)'(miss_rd);
      wsat = (wsum > (WGT_W+2)'(WEIGHT_MAX)) ? WEIGHT_MAX : wsum[WGT_W-1:0];
      csum = (COST_W+1)'(c0_ff) + (COST_W+1)'(cost_rd);
      tot  = (COST_W+2)'(best_ff) + (COST_W+2)'(w_ff);
      csat = (tot > (COST_W+2)'(COST_MAX)) ? COST_MAX : tot[COST_W-1:0];
   end

   logic wr_en;
   logic [CA_W-1:0] wr_a;
   logic [WGT_W-1:0] wr_w;
   logic [COST_W-1:0] wr_c;
   logic [KEY_W-1:0] wr_r;
   always_comb begin
      wr_en = 1'b0;
      wr_a  = cidx(i_ff, j_w);
      wr_w  = w_ff;
      wr_c  = csat;
      wr_r  = best_k_ff;
      if (state_ff == ST_CELL && len_ff == '0) begin
         wr_en = 1'b1;
         wr_w  = WGT_W'(miss_rd);
         wr_c  = '0;
         wr_r  = '0;
      end else if (state_ff == ST_WRITE && len_ff != '0) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wgt_mem[wr_a]  <= wr_w;
         cost_mem[wr_a] <= wr_c;
         root_mem[wr_a] <= wr_r;
      end
      wgt_rd  <= wgt_mem[wgt_ra];
      cost_rd <= cost_mem[cost_ra];
      root_rd <= root_mem[root_ra];
   end

   // emit stack memory
   logic stk_we;
   span_type stk_wd;
   always_comb begin
      stk_we = 1'b0;
      stk_wd = span_ff;
      if (state_ff == ST_PUSH) begin
         if (push_ff == 2'd0 && r_ff != span_ff.hi) begin
            stk_we = 1'b1;
            stk_wd = '{lo: r_ff, hi: span_ff.hi, parent: r_ff, left: 1'b0};
         end else if (push_ff == 2'd1 && span_ff.lo != r_ff - KEY_W'(1)) begin
            stk_we = 1'b1;
            stk_wd = '{lo: span_ff.lo, hi: r_ff - KEY_W'(1), parent: r_ff, left: 1'b1};
         end
      end
   end
   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[sp_ff] <= stk_wd;
      stk_rd <= stk_mem[sp_ff - SP_W'(1)];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         rsp_valid <= 1'b0;
         sp_ff     <= '0;
         push_ff   <= '0;
      end else begin
         if (rsp_fire && !emit_go) rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire && req_last_item && (req_key_index <= KEY_W'(MAX_KEYS))) begin
                  n_ff     <= req_key_index;
                  len_ff   <= '0;
                  i_ff     <= '0;
                  state_ff <= ST_WRD;
               end
            end
            ST_WRD: state_ff <= ST_CELL;   // weight/prefix reads in flight
            ST_CELL: begin
               if (len_ff == '0) begin
                  state_ff <= ST_WRITE;
               end else begin
                  w_ff      <= wsat;
                  k_ff      <= i_ff + KEY_W'(1);
                  best_k_ff <= i_ff + KEY_W'(1);
                  best_ff   <= '1;
                  state_ff  <= ST_KRD0;
               end
            end
            ST_KRD0: state_ff <= ST_KRD1;
            ST_KRD1: begin
               c0_ff    <= cost_rd;
               state_ff <= ST_KACC;
            end
            ST_KACC: begin
               if (csum < best_ff) begin
                  best_ff   <= csum;
                  best_k_ff <= k_ff;
               end
               if (k_ff == j_w) begin
                  state_ff <= ST_WRITE;
               end else begin
                  k_ff     <= k_ff + KEY_W'(1);
                  state_ff <= ST_KRD0;
               end
            end
            ST_WRITE: begin
               if (j_w != n_ff) begin
                  i_ff     <= i_ff + KEY_W'(1);
                  state_ff <= ST_WRD;
               end else if (len_ff != n_ff) begin
                  i_ff     <= '0;
                  len_ff   <= len_ff + KEY_W'(1);
                  state_ff <= ST_WRD;
               end else begin
                  state_ff <= ST_TOTAL;
                  push_ff  <= 2'd3;
               end
            end
            ST_TOTAL: begin
               // cost(0,n) read lands in the ST_TOTAL wait slot held by push_ff
               if (push_ff == 2'd3) begin
                  push_ff <= 2'd2;
               end else begin
                  total_ff <= cost_rd;
                  if (n_ff == '0) begin
                     rsp_node_key      <= '0;
                     rsp_parent_key    <= '0;
                     rsp_is_left_child <= 1'b0;
                     rsp_tree_cost     <= cost_rd;
                     rsp_last_result   <= 1'b1;
                     rsp_valid         <= 1'b1;
                     state_ff          <= ST_LOAD;
                  end else begin
                     span_ff  <= '{lo: '0, hi: n_ff, parent: '0, left: 1'b0};
                     state_ff <= ST_ROOT;
                  end
               end
            end
            ST_POP: begin
               if (sp_ff == '0) begin
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_OUT;
                  push_ff  <= 2'd2;
               end
            end
            ST_OUT: begin
               // stack read data ready; fetch root next
               span_ff  <= stk_rd;
               sp_ff    <= sp_ff - SP_W'(1);
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (push_ff == 2'd2) begin
                  push_ff <= 2'd3;
               end else if (emit_go) begin
                  r_ff              <= root_rd;
                  rsp_node_key      <= root_rd;
                  rsp_parent_key    <= span_ff.parent;
                  rsp_is_left_child <= span_ff.left;
                  rsp_tree_cost     <= total_ff;
                  rsp_last_result   <= emit_last;
                  rsp_valid         <= 1'b1;
                  push_ff           <= 2'd0;
                  state_ff          <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (stk_we) sp_ff <= sp_ff + SP_W'(1);
               if (push_ff == 2'd0) begin
                  push_ff <= 2'd1;
               end else begin
                  push_ff  <= 2'd2;
                  state_ff <= ST_POP;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   `include "optimal_bst_builder_assert.svh"

   `OBST_ASSERT_IMPL(a_no_load_busy, clock, reset, state_ff != ST_LOAD, !req_ready, "ready while busy")
   `OBST_ASSERT_IMPL(a_stack_bound, clock, reset, 1'b1, sp_ff <= SP_W'(SIDE + 1), "stack overflow")
   `OBST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_node_key), "result dropped")
endmodule
`default_nettype wire
